// File: rtl/core/tbl_pkg.sv
// Shared types and constants for the token bucket limiter.
`timescale 1ns / 1ps
package tbl_pkg;

  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned TOKEN_WIDTH = 32;
  localparam int unsigned FRAC_BITS   = 16;

  // Register values after reset: one token per tick, sixteen tokens of burst
  localparam logic [FIELD_W-1:0] RATE_RST  = FIELD_W'(32'd1 << FRAC_BITS);
  localparam logic [FIELD_W-1:0] BURST_RST = FIELD_W'(32'd16 << FRAC_BITS);

  // Configuration register indexes
  localparam logic [1:0] REG_TOKEN_RATE     = 2'd0;
  localparam logic [1:0] REG_BURST_SIZE     = 2'd1;
  localparam logic [1:0] REG_INITIAL_TOKENS = 2'd2;
  localparam logic [1:0] REG_START_FULL     = 2'd3;

  // One classified decision, passed from the front end to the back end
  typedef struct packed {
    logic               granted;
    logic [FIELD_W-1:0] avail;
    logic [FIELD_W-1:0] need;
    logic               div_en;
    logic               sat;
  } tbl_entry_t;

endpackage

// File: rtl/core/token_bucket_limiter_unit.sv
// Top level of the token bucket limiter: front end, decision queue, back end.
`timescale 1ns / 1ps
//
//  channel  direction  handshake                payload
//  in       sink       in_valid_i/in_stall_o    elapsed_ticks_i, request_tokens_i
//  out      source     out_valid_o/out_stall_i  granted_o, available_tokens_o, wait_ticks_o
//  cfg      sink       cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
//  The front end takes one item per cycle while the decision queue has room; the
//  refill multiply is registered, the level update and grant use it at the push.
//  A granted, zero or zero-rate request is registered at the output as it pops;
//  a refused request with a nonzero rate runs in the radix-2 divider for wait_ticks.
//  Reset loads the burst size as level; a stalled output holds and backs up the queue.
module token_bucket_limiter_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] elapsed_ticks_i,
  input  logic [31:0] request_tokens_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        granted_o,
  output logic [31:0] available_tokens_o,
  output logic [31:0] wait_ticks_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import tbl_pkg::*;

  logic        push, full, pop, empty;
  logic [31:0] token_rate;
  tbl_entry_t  push_entry, pop_entry;

  // Refill and decide, one transfer per cycle while the queue has room
  tbl_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .elapsed_ticks_i  (elapsed_ticks_i),
    .request_tokens_i (request_tokens_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .token_rate_o     (token_rate),
    .push_o           (push),
    .push_entry_o     (push_entry),
    .full_i           (full)
  );

  // Hold decisions while the divider is busy or the output is stalled
  tbl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry),
    .empty_o      (empty)
  );

  // Work out the wait time and drive the result transfer
  tbl_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .token_rate_i       (token_rate),
    .empty_i            (empty),
    .pop_o              (pop),
    .entry_i            (pop_entry),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .granted_o          (granted_o),
    .available_tokens_o (available_tokens_o),
    .wait_ticks_o       (wait_ticks_o)
  );

endmodule

// File: rtl/core/tbl_front.sv
// Front end: configuration registers, bucket level, refill and grant decision.
`timescale 1ns / 1ps
module tbl_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [31:0]          elapsed_ticks_i,
  input  logic [31:0]          request_tokens_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output logic [31:0]          token_rate_o,
  output logic                 push_o,
  output tbl_pkg::tbl_entry_t  push_entry_o,
  input  logic                 full_i
);
  import tbl_pkg::*;

  localparam int unsigned PW = 2 * FIELD_W;

  logic [FIELD_W-1:0]     rate_q, rate_d;
  logic [FIELD_W-1:0]     burst_q, burst_d;
  logic [FIELD_W-1:0]     init_q, init_d;
  logic                   start_full_q, start_full_d;
  logic [TOKEN_WIDTH-1:0] level_q, level_d;

  logic                   busy_q;
  logic [PW-1:0]          prod_q;
  logic [FIELD_W-1:0]     req_q;

  logic                   accept, cfg_wr;
  logic [TOKEN_WIDTH-1:0] cap, room, refilled, reload, after;
  logic                   fill_to_cap, req_nz, grant;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr       = cfg_valid_i & cfg_ready_o;
  assign push_o       = busy_q & ~full_i;
  assign in_stall_o   = busy_q & full_i;
  assign accept       = in_valid_i & ~in_stall_o;
  assign token_rate_o = rate_q;

  // Register writes
  always_comb begin
    rate_d       = rate_q;
    burst_d      = burst_q;
    init_d       = init_q;
    start_full_d = start_full_q;
    if (cfg_wr) begin
      case (cfg_index_i)
        REG_TOKEN_RATE:     rate_d       = cfg_data_i;
        REG_BURST_SIZE:     burst_d      = cfg_data_i;
        REG_INITIAL_TOKENS: init_d       = cfg_data_i;
        REG_START_FULL:     start_full_d = cfg_data_i[0];
        default:            rate_d       = rate_q;
      endcase
    end
  end

  assign reload = start_full_d ? burst_d : init_d;

  // Refill clamped at the capacity, then grant
  assign cap         = burst_q;
  assign room        = cap - level_q;
  assign fill_to_cap = (level_q >= cap) || (prod_q >= PW'(room));
  assign refilled    = fill_to_cap ? cap : level_q + prod_q[TOKEN_WIDTH-1:0];

  assign req_nz = req_q != '0;
  assign grant  = req_nz && (refilled >= req_q);
  assign after  = grant ? refilled - req_q : refilled;

  always_comb begin
    push_entry_o.granted = grant;
    push_entry_o.avail   = after;
    push_entry_o.need    = req_q - refilled;
    push_entry_o.div_en  = req_nz && !grant && (rate_q != '0);
    push_entry_o.sat     = req_nz && !grant && (rate_q == '0);
  end

  always_comb begin
    level_d = level_q;
    if (cfg_wr) begin
      level_d = reload;
    end else if (push_o) begin
      level_d = after;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q       <= RATE_RST;
      burst_q      <= BURST_RST;
      init_q       <= '0;
      start_full_q <= 1'b1;
      level_q      <= BURST_RST;
      busy_q       <= 1'b0;
    end else begin
      rate_q       <= rate_d;
      burst_q      <= burst_d;
      init_q       <= init_d;
      start_full_q <= start_full_d;
      level_q      <= level_d;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (push_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Product and request of the item in flight
  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q <= PW'(elapsed_ticks_i) * PW'(token_rate_o);
      req_q  <= request_tokens_i;
    end
  end

endmodule

// File: rtl/core/tbl_queue.sv
// Short decision queue between the front end and the back end.
`timescale 1ns / 1ps
module tbl_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tbl_pkg::tbl_entry_t push_entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output tbl_pkg::tbl_entry_t pop_entry_o,
  output logic                empty_o
);
  import tbl_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tbl_entry_t       slots_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o      = count_q == CNT_W'(DEPTH);
  assign empty_o     = count_q == '0;
  assign pop_entry_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full decision queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty decision queue");

endmodule

// File: rtl/core/tbl_back.sv
// Back end: radix-2 wait-time divider and output register.
`timescale 1ns / 1ps
module tbl_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         token_rate_i,
  input  logic                empty_i,
  output logic                pop_o,
  input  tbl_pkg::tbl_entry_t entry_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                granted_o,
  output logic [31:0]         available_tokens_o,
  output logic [31:0]         wait_ticks_o
);
  import tbl_pkg::*;

  localparam int unsigned DIV_STEPS = FIELD_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  logic               div_busy_q, out_valid_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [FIELD_W-1:0] rem_q, quot_q, avail_hold_q;
  logic               granted_q;
  logic [FIELD_W-1:0] avail_q, wait_q;

  logic               out_free, last, step, finish;
  logic [FIELD_W:0]   rem_sh, trial;
  logic               ge;
  logic [FIELD_W-1:0] rem_nx, quot_nx;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign last     = cnt_q == CNT_W'(DIV_STEPS - 1);
  assign step     = div_busy_q & (~last | out_free);
  assign finish   = div_busy_q & last & out_free;
  assign pop_o    = ~empty_i & ~div_busy_q & out_free;

  assign rem_sh  = {rem_q, quot_q[FIELD_W-1]};
  assign trial   = rem_sh - {1'b0, token_rate_i};
  assign ge      = rem_sh >= {1'b0, token_rate_i};
  assign rem_nx  = ge ? trial[FIELD_W-1:0] : rem_sh[FIELD_W-1:0];
  assign quot_nx = {quot_q[FIELD_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (pop_o && entry_i.div_en) begin
        div_busy_q <= 1'b1;
        cnt_q      <= '0;
      end else if (finish) begin
        div_busy_q <= 1'b0;
      end else if (step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (finish || (pop_o && !entry_i.div_en)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && entry_i.div_en) begin
      rem_q        <= '0;
      quot_q       <= entry_i.need;
      avail_hold_q <= entry_i.avail;
    end else if (step) begin
      rem_q  <= rem_nx;
      quot_q <= quot_nx;
    end
    if (finish) begin
      granted_q <= 1'b0;
      avail_q   <= avail_hold_q;
      wait_q    <= quot_nx;
    end else if (pop_o && !entry_i.div_en) begin
      granted_q <= entry_i.granted;
      avail_q   <= entry_i.avail;
      wait_q    <= entry_i.sat ? '1 : '0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign granted_o          = granted_q;
  assign available_tokens_o = avail_q;
  assign wait_ticks_o       = wait_q;

  a_grant_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && granted_o) |-> (wait_ticks_o == '0))
    else $error("granted result carries a wait time");
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy_q |-> (token_rate_i != '0)) else $error("divide by zero rate");
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && entry_i.div_en) |=> (div_busy_q && !out_valid_o) || $past(out_valid_q))
    else $error("divider start lost");

endmodule
